// File: design/hsq_pkg.sv
package hsq_pkg;

    localparam int TimeW   = 32;
    localparam int PosW    = 16;
    localparam int SumW    = 18;
    localparam int StepW   = 10;
    localparam int BackW   = 15;
    localparam int MsW     = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 32;
    localparam int InDataW = 72;
    localparam int OutDataW = 40;
    localparam int TargetLimit = 18000;

    typedef enum logic [1:0] {
        PH_SEEK    = 2'd0,
        PH_BACKOFF = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_ABORT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_DONE     = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_CONFLICT = 2'd3
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SEEK_PERIOD  = 3'd0,
        CFG_SEEK_STEP    = 3'd1,
        CFG_CONFIRM      = 3'd2,
        CFG_SETTLE       = 3'd3,
        CFG_TIMEOUT      = 3'd4,
        CFG_PAN_BACKOFF  = 3'd5,
        CFG_TILT_BACKOFF = 3'd6,
        CFG_SEEK_DIRS    = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic clear;
        logic update;
    } t_lane_ctrl;

    typedef struct packed {
        logic                   good;
        logic                   done;
        logic                   target_valid;
        logic signed [PosW-1:0] target;
    } t_lane_res;

    typedef struct packed {
        logic signed [PosW-1:0] tilt_target;
        logic                   tilt_target_valid;
        logic signed [PosW-1:0] pan_target;
        logic                   pan_target_valid;
        logic                   torque_on;
        logic                   is_active;
        t_status                status;
    } t_result;

    function automatic logic signed [PosW-1:0] sat_target(input logic signed [SumW-1:0] v);
        logic signed [SumW-1:0] lim;
        lim = SumW'(TargetLimit);
        if (v > lim) begin
            return PosW'(lim);
        end else if (v < -lim) begin
            return PosW'(-lim);
        end
        return v[PosW-1:0];
    endfunction

endpackage

// File: design/hsq_axis.sv
module hsq_axis (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hsq_pkg::t_lane_ctrl            i_ctrl,
    input  logic [hsq_pkg::TimeW-1:0]      i_now,
    input  logic                           i_switch,
    input  logic signed [hsq_pkg::PosW-1:0] i_position,
    input  logic                           i_seek_dir,
    input  logic [hsq_pkg::BackW-1:0]      i_backoff,
    input  logic [hsq_pkg::StepW-1:0]      i_seek_step,
    input  logic [hsq_pkg::MsW-1:0]        i_seek_period,
    input  logic [hsq_pkg::MsW-1:0]        i_confirm_ms,
    input  logic [hsq_pkg::MsW-1:0]        i_settle_ms,
    output hsq_pkg::t_lane_res             o_res
);
    import hsq_pkg::*;

    t_phase             r_phase, n_phase;
    logic               r_pend, n_pend;
    logic               r_good, n_good;
    logic [TimeW-1:0]   r_ctime, n_ctime;
    logic [TimeW-1:0]   r_btime, n_btime;
    logic [TimeW-1:0]   r_last, n_last;

    logic               tv;
    logic               neg;
    logic [BackW-1:0]   mag;
    logic [TimeW-1:0]   d_conf, d_settle, d_last;
    logic signed [SumW-1:0] mag_ext, sum;

    assign d_conf   = i_now - r_ctime;
    assign d_settle = i_now - r_btime;
    assign d_last   = i_now - r_last;

    always_comb begin
        n_phase = r_phase;
        n_pend  = r_pend;
        n_good  = r_good;
        n_ctime = r_ctime;
        n_btime = r_btime;
        n_last  = r_last;
        tv      = 1'b0;
        neg     = 1'b0;
        mag     = '0;
        if (i_ctrl.clear) begin
            n_phase = PH_SEEK;
            n_pend  = 1'b0;
            n_good  = 1'b1;
            n_last  = i_now;
        end else if (i_ctrl.update) begin
            case (r_phase)
                PH_SEEK: begin
                    if (i_switch) begin
                        if (!r_pend) begin
                            n_pend  = 1'b1;
                            n_ctime = i_now;
                        end else if (d_conf >= TimeW'(i_confirm_ms)) begin
                            n_phase = PH_BACKOFF;
                            n_btime = i_now;
                            tv      = 1'b1;
                            neg     = i_seek_dir;
                            mag     = i_backoff;
                        end
                    end else begin
                        if (r_pend && (d_conf > TimeW'(i_confirm_ms))) begin
                            n_good = 1'b0;
                        end
                        n_pend = 1'b0;
                        if (d_last >= TimeW'(i_seek_period)) begin
                            n_last = i_now;
                            tv     = 1'b1;
                            neg    = !i_seek_dir;
                            mag    = BackW'(i_seek_step);
                        end
                    end
                end
                PH_BACKOFF: begin
                    if (r_good && (d_settle >= TimeW'(i_settle_ms))) begin
                        if (i_switch) begin
                            n_good = 1'b0;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign mag_ext = SumW'(mag);
    assign sum = SumW'(i_position) + (neg ? -mag_ext : mag_ext);

    always_comb begin
        o_res.good         = n_good;
        o_res.done         = n_good && (n_phase == PH_DONE);
        o_res.target_valid = tv;
        o_res.target       = tv ? sat_target(sum) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_pend  <= 1'b0;
            r_good  <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_good  <= n_good;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctime <= n_ctime;
        r_btime <= n_btime;
        r_last  <= n_last;
    end

    a_done_is_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> r_good)
        else $error("axis reached done with a bad switch");

    a_backoff_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEEK && n_phase == PH_BACKOFF) |-> tv)
        else $error("backoff entered without a target");

    a_clear_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.clear |=> (r_phase == PH_SEEK && r_good && !r_pend))
        else $error("clear did not rearm the axis");

endmodule

// File: design/hsq_merge.sv
module hsq_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [1:0]                i_op,
    input  logic [hsq_pkg::TimeW-1:0] i_now,
    input  logic [hsq_pkg::TimeW-1:0] i_timeout_ms,
    input  hsq_pkg::t_lane_res        i_pan,
    input  hsq_pkg::t_lane_res        i_tilt,
    output hsq_pkg::t_lane_ctrl       o_ctrl,
    output hsq_pkg::t_result          o_result
);
    import hsq_pkg::*;

    logic             r_running, n_running;
    logic [TimeW-1:0] r_start, n_start;
    logic             timed_out;
    t_status          status;
    logic             torque;

    assign timed_out = (i_now - r_start) > i_timeout_ms;

    always_comb begin
        o_ctrl.clear  = 1'b0;
        o_ctrl.update = 1'b0;
        case (i_op)
            OP_START: begin
                o_ctrl.clear = i_accept && !r_running;
            end
            OP_TICK: begin
                o_ctrl.update = i_accept && r_running && !timed_out;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_running     = r_running;
        n_start       = r_start;
        status        = ST_RUNNING;
        torque        = 1'b0;
        case (i_op)
            OP_START: begin
                if (!r_running) begin
                    n_start      = i_now;
                    n_running    = 1'b1;
                    torque       = 1'b1;
                end
            end
            OP_ABORT: begin
                n_running = 1'b0;
            end
            OP_TICK: begin
                if (!r_running) begin
                    status = ST_DONE;
                end else if (timed_out) begin
                    n_running = 1'b0;
                    status    = ST_TIMEOUT;
                end else begin
                    if (!i_pan.good || !i_tilt.good) begin
                        n_running = 1'b0;
                        status    = ST_CONFLICT;
                    end else if (i_pan.done && i_tilt.done) begin
                        n_running = 1'b0;
                        status    = ST_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.status            = status;
        o_result.is_active         = n_running;
        o_result.torque_on         = torque;
        o_result.pan_target_valid  = i_pan.target_valid;
        o_result.pan_target        = i_pan.target;
        o_result.tilt_target_valid = i_tilt.target_valid;
        o_result.tilt_target       = i_tilt.target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
        end else if (i_accept) begin
            r_running <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_start <= n_start;
        end
    end

    a_start_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_running) |-> $past(i_accept && i_op == OP_START))
        else $error("homing began without a start transfer");

    a_conflict_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && status == ST_CONFLICT) |=> !r_running)
        else $error("conflict left the sequence running");

    a_lanes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.clear && o_ctrl.update))
        else $error("lanes cleared and updated together");

endmodule

// File: design/two_axis_homing_sequencer.sv
// The lanes and merge compute results combinationally into r_out or r_skid.
// Throughput: one item per cycle while s_axis_tready is high.
// A two-entry output buffer keeps s_axis_tready high while one result waits downstream.
// Reset (synchronous, active low) idles the sequencer, rearms both axes and
// loads the default configuration; the block is usable on the next cycle.
module two_axis_homing_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_ms[31:0], pan_switch[32], tilt_switch[33], pan_position[49:34],
    // tilt_position[65:50], zero fill above.
    input  logic [hsq_pkg::InDataW-1:0]        s_axis_tdata,
    // op[1:0].
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[1:0], is_active[2], torque_on[3], pan_target_valid[4],
    // pan_target[20:5], tilt_target_valid[21], tilt_target[37:22], zero fill above.
    output logic [hsq_pkg::OutDataW-1:0]       m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hsq_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [hsq_pkg::CfgW-1:0]           i_cfg_data
);
    import hsq_pkg::*;

    logic [MsW-1:0]   r_seek_period;
    logic [StepW-1:0] r_seek_step;
    logic [MsW-1:0]   r_confirm;
    logic [MsW-1:0]   r_settle;
    logic [TimeW-1:0] r_timeout;
    logic [BackW-1:0] r_pan_backoff;
    logic [BackW-1:0] r_tilt_backoff;
    logic [1:0]       r_seek_dirs;

    logic             in_accept;
    logic             out_pop;
    t_lane_ctrl       lane_ctrl;
    t_lane_res        pan_res, tilt_res;
    t_result          result;

    logic             r_out_valid, r_skid_valid;
    t_result          r_out, r_skid;

    logic [TimeW-1:0]      now;
    logic signed [PosW-1:0] pan_pos, tilt_pos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seek_period  <= MsW'(20);
            r_seek_step    <= StepW'(50);
            r_confirm      <= MsW'(30);
            r_settle       <= MsW'(200);
            r_timeout      <= TimeW'(15000);
            r_pan_backoff  <= BackW'(500);
            r_tilt_backoff <= BackW'(500);
            r_seek_dirs    <= 2'b00;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SEEK_PERIOD:  r_seek_period  <= i_cfg_data[MsW-1:0];
                CFG_SEEK_STEP:    r_seek_step    <= i_cfg_data[StepW-1:0];
                CFG_CONFIRM:      r_confirm      <= i_cfg_data[MsW-1:0];
                CFG_SETTLE:       r_settle       <= i_cfg_data[MsW-1:0];
                CFG_TIMEOUT:      r_timeout      <= i_cfg_data[TimeW-1:0];
                CFG_PAN_BACKOFF:  r_pan_backoff  <= i_cfg_data[BackW-1:0];
                CFG_TILT_BACKOFF: r_tilt_backoff <= i_cfg_data[BackW-1:0];
                CFG_SEEK_DIRS:    r_seek_dirs    <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = r_out_valid && m_axis_tready;

    assign now      = s_axis_tdata[31:0];
    assign pan_pos  = s_axis_tdata[49:34];
    assign tilt_pos = s_axis_tdata[65:50];

    hsq_axis u_pan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (lane_ctrl),
        .i_now         (now),
        .i_switch      (s_axis_tdata[32]),
        .i_position    (pan_pos),
        .i_seek_dir    (r_seek_dirs[0]),
        .i_backoff     (r_pan_backoff),
        .i_seek_step   (r_seek_step),
        .i_seek_period (r_seek_period),
        .i_confirm_ms  (r_confirm),
        .i_settle_ms   (r_settle),
        .o_res         (pan_res)
    );

    hsq_axis u_tilt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (lane_ctrl),
        .i_now         (now),
        .i_switch      (s_axis_tdata[33]),
        .i_position    (tilt_pos),
        .i_seek_dir    (r_seek_dirs[1]),
        .i_backoff     (r_tilt_backoff),
        .i_seek_step   (r_seek_step),
        .i_seek_period (r_seek_period),
        .i_confirm_ms  (r_confirm),
        .i_settle_ms   (r_settle),
        .o_res         (tilt_res)
    );

    hsq_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_op         (s_axis_tuser),
        .i_now        (now),
        .i_timeout_ms (r_timeout),
        .i_pan        (pan_res),
        .i_tilt       (tilt_res),
        .o_ctrl       (lane_ctrl),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (r_out_valid && !out_pop) begin
                r_skid_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (r_out_valid && !out_pop) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutDataW'(r_out);

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("buffered result without a head result");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("result dropped while downstream stalled");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_axis_tready) |=> (r_out_valid && !r_skid_valid))
        else $error("buffered result not moved forward");

endmodule

// File: tb/sv/tb_two_axis_homing_sequencer.sv
module tb_two_axis_homing_sequencer;
    import hsq_pkg::*;

    localparam logic [1:0] OpUnused = 2'd3;
    localparam int CycleLimit = 500000;
    localparam int LongStall = 60;
    localparam int ItemTarget = 1300;

    typedef enum int {
        SW_OPEN,
        SW_CLOSING,
        SW_HELD,
        SW_RELEASED
    } t_switch_plan;

    typedef struct {
        logic [1:0]         op;
        logic [InDataW-1:0] data;
    } t_homing_item;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgW-1:0]     i_cfg_data = '0;

    two_axis_homing_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the configuration and the homing state.
    logic [MsW-1:0]   cfg_period;
    logic [StepW-1:0] cfg_step;
    logic [MsW-1:0]   cfg_confirm;
    logic [MsW-1:0]   cfg_settle;
    logic [TimeW-1:0] cfg_timeout;
    logic [BackW-1:0] cfg_pan_back;
    logic [BackW-1:0] cfg_tilt_back;
    logic [1:0]       cfg_dirs;

    logic             homing_on;
    logic [TimeW-1:0] homing_t0;
    t_phase           ax_phase [2];
    logic             ax_pend [2];
    logic [TimeW-1:0] ax_pend_t [2];
    logic [TimeW-1:0] ax_back_t [2];
    logic [TimeW-1:0] ax_step_t [2];
    logic             ax_good [2];

    t_homing_item homing_items [$];
    t_result      homing_outcomes [$];
    t_homing_item cur_item;
    t_result      want_r;
    t_result      got_r;

    int n_queued = 0;
    int n_taken = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int tx_gap = 0;
    int tx_gap_max = 0;
    int rx_wait = 0;
    int rx_gap_max = 0;
    int stall_requests = 0;
    int stall_served = 0;
    int stall_left = 0;
    int phase_no;
    int seq_no;
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic [TimeW-1:0] clock_ms;

    function automatic void rearm_axes(input logic [TimeW-1:0] t);
        for (int a = 0; a < 2; a++) begin
            ax_phase[a] = PH_SEEK;
            ax_pend[a] = 1'b0;
            ax_pend_t[a] = '0;
            ax_back_t[a] = '0;
            ax_step_t[a] = t;
            ax_good[a] = 1'b1;
        end
    endfunction

    function automatic logic signed [PosW-1:0] clamp_target(input int v);
        if (v > TargetLimit) begin
            return PosW'(TargetLimit);
        end
        if (v < -TargetLimit) begin
            return PosW'(-TargetLimit);
        end
        return PosW'(v);
    endfunction

    function automatic logic axis_advance(input int a, input logic [TimeW-1:0] now,
                                          input logic sw, input logic signed [PosW-1:0] pos,
                                          output logic tv, output logic signed [PosW-1:0] tgt);
        int dir;
        int back;
        int pos_i;
        dir = cfg_dirs[a] ? 1 : -1;
        back = (a == 0) ? int'(cfg_pan_back) : int'(cfg_tilt_back);
        pos_i = pos;
        tv = 1'b0;
        tgt = '0;
        if (ax_phase[a] == PH_SEEK) begin
            if (sw) begin
                if (!ax_pend[a]) begin
                    ax_pend[a] = 1'b1;
                    ax_pend_t[a] = now;
                end else if (TimeW'(now - ax_pend_t[a]) >= TimeW'(cfg_confirm)) begin
                    ax_phase[a] = PH_BACKOFF;
                    ax_back_t[a] = now;
                    tv = 1'b1;
                    tgt = clamp_target(pos_i - dir * back);
                end
            end else begin
                if (ax_pend[a] && TimeW'(now - ax_pend_t[a]) > TimeW'(cfg_confirm)) begin
                    ax_good[a] = 1'b0;
                end
                ax_pend[a] = 1'b0;
                if (TimeW'(now - ax_step_t[a]) >= TimeW'(cfg_period)) begin
                    ax_step_t[a] = now;
                    tv = 1'b1;
                    tgt = clamp_target(pos_i + dir * int'(cfg_step));
                end
            end
        end else if (ax_phase[a] == PH_BACKOFF) begin
            if (ax_good[a] && TimeW'(now - ax_back_t[a]) >= TimeW'(cfg_settle)) begin
                if (sw) begin
                    ax_good[a] = 1'b0;
                end else begin
                    ax_phase[a] = PH_DONE;
                end
            end
        end
        return ax_good[a] && ax_phase[a] == PH_DONE;
    endfunction

    function automatic t_result predict_homing(input logic [1:0] op,
                                               input logic [TimeW-1:0] now,
                                               input logic [1:0] sw,
                                               input logic signed [PosW-1:0] pan_pos,
                                               input logic signed [PosW-1:0] tilt_pos);
        t_result r;
        logic pan_fin;
        logic tilt_fin;
        logic pan_tv;
        logic tilt_tv;
        logic signed [PosW-1:0] pan_tgt;
        logic signed [PosW-1:0] tilt_tgt;
        r = '0;
        r.status = ST_RUNNING;
        case (op)
            OP_START: begin
                if (!homing_on) begin
                    rearm_axes(now);
                    homing_t0 = now;
                    homing_on = 1'b1;
                    r.torque_on = 1'b1;
                end
            end
            OP_ABORT: begin
                homing_on = 1'b0;
            end
            OP_TICK: begin
                if (!homing_on) begin
                    r.status = ST_DONE;
                end else if (TimeW'(now - homing_t0) > cfg_timeout) begin
                    homing_on = 1'b0;
                    r.status = ST_TIMEOUT;
                end else begin
                    pan_fin = axis_advance(0, now, sw[0], pan_pos, pan_tv, pan_tgt);
                    tilt_fin = axis_advance(1, now, sw[1], tilt_pos, tilt_tv, tilt_tgt);
                    r.pan_target_valid = pan_tv;
                    r.pan_target = pan_tgt;
                    r.tilt_target_valid = tilt_tv;
                    r.tilt_target = tilt_tgt;
                    if (!ax_good[0] || !ax_good[1]) begin
                        homing_on = 1'b0;
                        r.status = ST_CONFLICT;
                    end else if (pan_fin && tilt_fin) begin
                        homing_on = 1'b0;
                        r.status = ST_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
        r.is_active = homing_on;
        return r;
    endfunction

    // Input side: predicts each accepted transfer and follows register writes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_period = 16'd20;
            cfg_step = 10'd50;
            cfg_confirm = 16'd30;
            cfg_settle = 16'd200;
            cfg_timeout = 32'd15000;
            cfg_pan_back = 15'd500;
            cfg_tilt_back = 15'd500;
            cfg_dirs = 2'd0;
            homing_on = 1'b0;
            homing_t0 = '0;
            rearm_axes('0);
            in_taken <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEEK_PERIOD:  cfg_period = i_cfg_data[MsW-1:0];
                    CFG_SEEK_STEP:    cfg_step = i_cfg_data[StepW-1:0];
                    CFG_CONFIRM:      cfg_confirm = i_cfg_data[MsW-1:0];
                    CFG_SETTLE:       cfg_settle = i_cfg_data[MsW-1:0];
                    CFG_TIMEOUT:      cfg_timeout = i_cfg_data[TimeW-1:0];
                    CFG_PAN_BACKOFF:  cfg_pan_back = i_cfg_data[BackW-1:0];
                    CFG_TILT_BACKOFF: cfg_tilt_back = i_cfg_data[BackW-1:0];
                    default:          cfg_dirs = i_cfg_data[1:0];
                endcase
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                homing_outcomes.push_back(predict_homing(s_axis_tuser, s_axis_tdata[31:0],
                                                         s_axis_tdata[33:32],
                                                         s_axis_tdata[49:34],
                                                         s_axis_tdata[65:50]));
                n_taken++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (homing_items.size() != 0) begin
                cur_item = homing_items.pop_front();
                s_axis_tuser <= cur_item.op;
                s_axis_tdata <= cur_item.data;
                s_axis_tvalid <= 1'b1;
                tx_gap = $urandom_range(0, tx_gap_max);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_served != stall_requests) begin
            stall_served++;
            stall_left = LongStall;
            m_axis_tready <= 1'b0;
        end else begin
            if (out_taken) begin
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        out_taken <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r = m_axis_tdata[$bits(t_result)-1:0];
            if (homing_outcomes.size() == 0) begin
                $error("result transfer with no expected result pending");
                n_errors++;
            end else begin
                want_r = homing_outcomes.pop_front();
                check_field("status", int'(want_r.status), int'(got_r.status));
                check_field("is_active", int'(want_r.is_active), int'(got_r.is_active));
                check_field("torque_on", int'(want_r.torque_on), int'(got_r.torque_on));
                check_field("pan_target_valid", int'(want_r.pan_target_valid),
                            int'(got_r.pan_target_valid));
                check_field("pan_target", int'(want_r.pan_target), int'(got_r.pan_target));
                check_field("tilt_target_valid", int'(want_r.tilt_target_valid),
                            int'(got_r.tilt_target_valid));
                check_field("tilt_target", int'(want_r.tilt_target), int'(got_r.tilt_target));
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CycleLimit) begin
            $display("tb_two_axis_homing_sequencer: FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] op, input logic [TimeW-1:0] now,
                             input logic [1:0] sw, input logic signed [PosW-1:0] pan_pos,
                             input logic signed [PosW-1:0] tilt_pos);
        t_homing_item it;
        it.op = op;
        it.data = {6'd0, tilt_pos, pan_pos, sw, now};
        homing_items.push_back(it);
        n_queued++;
    endtask

    function automatic logic signed [PosW-1:0] rand_pos();
        if ($urandom_range(0, 6) == 0) begin
            return PosW'($urandom());
        end
        return PosW'(int'($urandom_range(0, 2 * TargetLimit)) - TargetLimit);
    endfunction

    task automatic wait_drained();
        while (n_taken != n_queued || homing_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CfgW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gap_max();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 2;
            default: return 10;
        endcase
    endfunction

    task automatic load_settings(input int kind);
        logic [CfgW-1:0] period;
        logic [CfgW-1:0] step;
        logic [CfgW-1:0] confirm;
        logic [CfgW-1:0] settle;
        logic [CfgW-1:0] limit;
        logic [CfgW-1:0] pan_back;
        logic [CfgW-1:0] tilt_back;
        period = $urandom_range(1, 40);
        step = $urandom_range(1, 1000);
        confirm = $urandom_range(0, 40);
        settle = $urandom_range(0, 120);
        limit = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 400)
                                            : $urandom_range(2000, 100000);
        pan_back = $urandom_range(0, TargetLimit);
        tilt_back = $urandom_range(0, TargetLimit);
        if ($urandom_range(0, 9) == 0) begin
            limit = $urandom();
        end
        if (kind == 1) begin
            period = 1;
            step = 1;
            confirm = 0;
            settle = 0;
            limit = 1;
            pan_back = 0;
            tilt_back = 0;
        end else if (kind == 2) begin
            period = 65535;
            step = 1000;
            confirm = 65535;
            settle = 65535;
            limit = 32'hFFFF_FFFF;
            pan_back = TargetLimit;
            tilt_back = TargetLimit;
        end else if (kind == 4) begin
            period = 0;
            step = ($urandom_range(0, 1) != 0) ? 1023 : 0;
            pan_back = 32767;
            tilt_back = $urandom_range(TargetLimit + 1, 32767);
        end
        write_reg(CFG_SEEK_PERIOD, period);
        write_reg(CFG_SEEK_STEP, step);
        write_reg(CFG_CONFIRM, confirm);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_TIMEOUT, limit);
        write_reg(CFG_PAN_BACKOFF, pan_back);
        write_reg(CFG_TILT_BACKOFF, tilt_back);
        write_reg(CFG_SEEK_DIRS, $urandom_range(0, 3));
    endtask

    // One homing attempt: seek with the switch open, close it long enough to confirm,
    // hold it briefly and release it, with bounces, stuck switches and noise mixed in.
    task automatic queue_homing();
        t_switch_plan plan [2];
        logic pend [2];
        logic [TimeW-1:0] pend_t [2];
        logic [TimeW-1:0] conf_at [2];
        int hold [2];
        logic [1:0] sw;
        int dt_max;
        int n_ticks;
        int tail;
        int k;
        dt_max = 1 + (int'(cfg_confirm) + int'(cfg_settle) + int'(cfg_period)) / 6;
        n_ticks = $urandom_range(4, 80);
        tail = -1;
        for (int a = 0; a < 2; a++) begin
            plan[a] = SW_OPEN;
            pend[a] = 1'b0;
            pend_t[a] = '0;
            conf_at[a] = '0;
            hold[a] = 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        end
        if ($urandom_range(0, 9) != 0) begin
            push_item(OP_START, clock_ms, 2'($urandom()), rand_pos(), rand_pos());
        end
        for (k = 0; k < n_ticks && tail != 0; k++) begin
            clock_ms = clock_ms + $urandom_range(0, dt_max);
            if ($urandom_range(0, 49) == 0) begin
                clock_ms = clock_ms + $urandom_range(0, 70000);
            end
            for (int a = 0; a < 2; a++) begin
                if (plan[a] == SW_OPEN && $urandom_range(0, 4) == 0) begin
                    plan[a] = SW_CLOSING;
                end
                case (plan[a])
                    SW_OPEN: begin
                        sw[a] = 1'b0;
                    end
                    SW_CLOSING: begin
                        sw[a] = ($urandom_range(0, 9) != 0);
                        if (!sw[a]) begin
                            pend[a] = 1'b0;
                        end else if (!pend[a]) begin
                            pend[a] = 1'b1;
                            pend_t[a] = clock_ms;
                        end else if (TimeW'(clock_ms - pend_t[a]) >= TimeW'(cfg_confirm)) begin
                            plan[a] = SW_HELD;
                            conf_at[a] = clock_ms;
                            hold[a] = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 3);
                        end
                    end
                    SW_HELD: begin
                        sw[a] = (hold[a] > 0);
                        if (hold[a] > 0) begin
                            hold[a]--;
                        end else begin
                            plan[a] = SW_RELEASED;
                        end
                    end
                    default: begin
                        sw[a] = ($urandom_range(0, 29) == 0);
                    end
                endcase
            end
            if ($urandom_range(0, 24) == 0) begin
                case ($urandom_range(0, 2))
                    0: push_item(OpUnused, $urandom(), 2'($urandom()), rand_pos(), rand_pos());
                    1: push_item(OP_START, clock_ms, 2'($urandom()), rand_pos(), rand_pos());
                    default: push_item(OP_ABORT, clock_ms, 2'($urandom()), rand_pos(),
                                       rand_pos());
                endcase
            end
            push_item(OP_TICK, clock_ms, sw, rand_pos(), rand_pos());
            if (tail > 0) begin
                tail--;
            end else if (tail < 0 && plan[0] == SW_RELEASED && plan[1] == SW_RELEASED
                         && TimeW'(clock_ms - conf_at[0]) >= TimeW'(cfg_settle)
                         && TimeW'(clock_ms - conf_at[1]) >= TimeW'(cfg_settle)) begin
                tail = 2;
            end
        end
        push_item(OP_ABORT, clock_ms, 2'($urandom()), rand_pos(), rand_pos());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle handling, then a full homing run on the reset settings that ends in done.
        push_item(OP_TICK, 32'd10, 2'b00, 16'sd0, 16'sd0);
        push_item(OpUnused, 32'd11, 2'b11, -16'sd1, 16'sd1);
        push_item(OP_ABORT, 32'd12, 2'b00, 16'sd0, 16'sd0);
        push_item(OP_START, 32'd1000, 2'b00, 16'sd18000, -16'sd18000);
        push_item(OP_START, 32'd1005, 2'b00, 16'sd0, 16'sd0);
        push_item(OP_TICK, 32'd1010, 2'b00, 16'sd100, 16'sd100);
        push_item(OP_TICK, 32'd1020, 2'b00, -16'sd18000, 16'h7FFF);
        push_item(OP_TICK, 32'd1030, 2'b11, 16'sd17800, 16'h8000);
        push_item(OP_TICK, 32'd1060, 2'b11, 16'sd17800, 16'h8000);
        push_item(OP_TICK, 32'd1100, 2'b11, 16'sd17800, 16'h8000);
        push_item(OP_TICK, 32'd1260, 2'b00, 16'sd0, 16'sd0);
        // A switch lost after the confirm window has run out.
        push_item(OP_START, 32'd2000, 2'b00, 16'sd0, 16'sd0);
        push_item(OP_TICK, 32'd2010, 2'b01, 16'sd0, 16'sd0);
        push_item(OP_TICK, 32'd2050, 2'b00, 16'sd0, 16'sd0);
        // Timeout one millisecond past the limit.
        push_item(OP_START, 32'd3000, 2'b00, 16'sd0, 16'sd0);
        push_item(OP_TICK, 32'd18001, 2'b00, 16'sd0, 16'sd0);
        // Time wrapping through zero, then an abort.
        push_item(OP_START, 32'hFFFF_FFFA, 2'b00, 16'sd5, -16'sd5);
        push_item(OP_TICK, 32'd5, 2'b00, 16'sd5, -16'sd5);
        push_item(OP_TICK, 32'd30, 2'b00, 16'sd5, -16'sd5);
        push_item(OP_ABORT, 32'd31, 2'b00, 16'sd0, 16'sd0);
        push_item(OP_TICK, 32'd40, 2'b00, 16'sd0, 16'sd0);
        // Switch still closed once the settle time has passed.
        push_item(OP_START, 32'd100, 2'b00, 16'sd0, 16'sd0);
        push_item(OP_TICK, 32'd110, 2'b01, 16'sd300, 16'sd0);
        push_item(OP_TICK, 32'd140, 2'b01, 16'sd300, 16'sd0);
        push_item(OP_TICK, 32'd340, 2'b01, 16'sd300, 16'sd0);

        clock_ms = $urandom();
        phase_no = 0;
        while (n_queued < ItemTarget) begin
            wait_drained();
            repeat (2) @(posedge i_clk);
            load_settings(phase_no);
            tx_gap_max = pick_gap_max();
            rx_gap_max = pick_gap_max();
            if (phase_no % 4 == 3) begin
                tx_gap_max = 0;
                stall_requests++;
            end
            for (seq_no = 0; seq_no < 4; seq_no++) begin
                queue_homing();
            end
            phase_no++;
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_two_axis_homing_sequencer: PASS");
        end else begin
            $display("tb_two_axis_homing_sequencer: FAIL");
        end
        $finish;
    end

endmodule

// File: two_axis_homing_sequencer.f
design/hsq_pkg.sv
design/hsq_axis.sv
design/hsq_merge.sv
design/two_axis_homing_sequencer.sv
tb/sv/tb_two_axis_homing_sequencer.sv
